// ===== hw/rtl/rgbhsv_pkg.sv =====
// Shared types and constants for the RGB/HSV/HSL color converter.
// Holds field widths, the mode codes, the request/response structs and the
// divider lane format. No dependencies.
`default_nettype none
package rgbhsv_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int HUE_FRAC_BITS = 8;

   localparam int CH_W    = CHANNEL_BITS;
   localparam int HUE_W   = HUE_FRAC_BITS + 3;
   localparam int FIRST_W = (HUE_W > CH_W) ? HUE_W : CH_W;
   // quotient holds up to max(full scale, one hue sector)
   localparam int QUO_W   = ((CH_W > HUE_FRAC_BITS) ? CH_W : HUE_FRAC_BITS) + 1;
   localparam int PROD_W  = 2 * CH_W + 1;
   localparam int NUM_W   = 2 * CH_W + HUE_FRAC_BITS + 2;
   localparam int DEN_W   = CH_W + HUE_FRAC_BITS + 1;
   localparam int W_W     = HUE_FRAC_BITS + 1;

   localparam logic [CH_W-1:0]  CH_MAX   = {CH_W{1'b1}};
   localparam logic [HUE_W:0]   HUE_ONE  = (HUE_W + 1)'(1) << HUE_FRAC_BITS;
   localparam logic [HUE_W:0]   HUE_TURN = (HUE_W + 1)'(6) << HUE_FRAC_BITS;

   typedef enum logic [1:0] {
      MODE_RGB2HSV = 2'd0,
      MODE_HSV2RGB = 2'd1,
      MODE_RGB2HSL = 2'd2,
      MODE_HSL2RGB = 2'd3
   } mode_type;

   // hue sector offset picked by the largest channel
   typedef enum logic [1:0] {
      HUE_BASE_RED   = 2'd0,
      HUE_BASE_GREEN = 2'd1,
      HUE_BASE_BLUE  = 2'd2
   } hue_base_type;

   typedef struct packed {
      logic [FIRST_W-1:0] in_first;
      logic [CH_W-1:0]    in_second;
      logic [CH_W-1:0]    in_third;
   } req_type;

   typedef struct packed {
      logic [FIRST_W-1:0] out_first;
      logic [CH_W-1:0]    out_second;
      logic [CH_W-1:0]    out_third;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } lane_type;

   typedef struct packed {
      mode_type     mode;
      logic [2:0]   sector;
      logic         neg;
      logic         hue_zero;
      logic         sat_zero;
      hue_base_type hue_base;
      logic [CH_W-1:0] third;
   } side_type;

   typedef struct packed {
      side_type            side;
      lane_type [2:0]      lane;
   } work_type;

endpackage
`default_nettype wire

// ===== hw/rtl/rgbhsv_prep.sv =====
// Two-stage front end: channel min/max or hue unpacking, then the
// rounded numerators and denominators for the divider chain.
// Depends on rgbhsv_pkg.
`default_nettype none
module rgbhsv_prep
   import rgbhsv_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire mode_type mode,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire req_type  in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output work_type      out_data
);

   typedef struct packed {
      side_type          side;
      logic [CH_W-1:0]   delta;
      logic [CH_W-1:0]   diff;
      logic [CH_W:0]     sat_den;
      logic [PROD_W-1:0] base;
      logic [PROD_W-1:0] span;
      logic [W_W-1:0]    w;
   } s1_type;

   logic     s1_valid_ff, s1_valid_in, s2_valid_ff, s2_valid_in;
   logic     s1_ready, s2_ready;
   s1_type   s1_ff, s1_in;
   work_type s2_ff, s2_in;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   // stage one
   always_comb begin
      logic [CH_W-1:0]   r, g, b, mx, mn, a_v, b_v;
      logic [CH_W:0]     sum, twol, k;
      logic [HUE_W-1:0]  hue;
      logic [PROD_W-1:0] ks;
      r = (in_data.in_first > FIRST_W'(CH_MAX)) ? CH_MAX : in_data.in_first[CH_W-1:0];
      g = in_data.in_second;
      b = in_data.in_third;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      s1_in = '0;
      s1_in.side.mode = mode;
      s1_in.delta = mx - mn;
      if (mx == r) begin
         s1_in.side.hue_base = HUE_BASE_RED;
         a_v = g;
         b_v = b;
      end else if (mx == g) begin
         s1_in.side.hue_base = HUE_BASE_GREEN;
         a_v = b;
         b_v = r;
      end else begin
         s1_in.side.hue_base = HUE_BASE_BLUE;
         a_v = r;
         b_v = g;
      end
      s1_in.side.neg = a_v < b_v;
      s1_in.diff = (a_v < b_v) ? (b_v - a_v) : (a_v - b_v);
      s1_in.side.hue_zero = (mx == mn);
      sum = {1'b0, mx} + {1'b0, mn};
      // reverse path: fold hue into one turn, pick sector weight
      hue = (in_data.in_first >= FIRST_W'(HUE_TURN)) ?
            HUE_W'(in_data.in_first - FIRST_W'(HUE_TURN)) : HUE_W'(in_data.in_first);
      s1_in.side.sector = hue[HUE_W-1:HUE_FRAC_BITS];
      s1_in.w = hue[HUE_FRAC_BITS] ?
                W_W'(HUE_ONE) - W_W'(hue[HUE_FRAC_BITS-1:0]) :
                W_W'(hue[HUE_FRAC_BITS-1:0]);
      twol = {b, 1'b0};
      k = (twol <= {1'b0, CH_MAX}) ? twol : ({CH_MAX, 1'b0} - twol);
      ks = PROD_W'(k) * PROD_W'(g);
      unique case (mode)
         MODE_RGB2HSV: begin
            s1_in.sat_den = {1'b0, mx};
            s1_in.side.sat_zero = (mx == '0);
            s1_in.side.third = mx;
         end
         MODE_RGB2HSL: begin
            s1_in.sat_den = (sum <= {1'b0, CH_MAX}) ? sum : ({CH_MAX, 1'b0} - sum);
            s1_in.side.sat_zero = (mx == mn) ||
               (((sum <= {1'b0, CH_MAX}) ? sum : ({CH_MAX, 1'b0} - sum)) == '0);
            s1_in.side.third = CH_W'((sum + 1'b1) >> 1);
         end
         MODE_HSV2RGB: begin
            s1_in.base = PROD_W'(b) * PROD_W'(CH_MAX - g);
            s1_in.span = PROD_W'(b) * PROD_W'(g);
         end
         MODE_HSL2RGB: begin
            s1_in.base = PROD_W'({b, 1'b0}) * PROD_W'(CH_MAX) - ks;
            s1_in.span = ks << 1;
         end
         default: s1_in.sat_den = '0;
      endcase
   end

   // stage two
   always_comb begin
      logic [DEN_W-1:0] rden, sden;
      logic [NUM_W-1:0] base_sh;
      s2_in = '0;
      s2_in.side = s1_ff.side;
      rden = (s1_ff.side.mode == MODE_HSL2RGB) ?
             DEN_W'(CH_MAX) << (HUE_FRAC_BITS + 1) : DEN_W'(CH_MAX) << HUE_FRAC_BITS;
      base_sh = NUM_W'(s1_ff.base) << HUE_FRAC_BITS;
      sden = s1_ff.side.sat_zero ? DEN_W'(1) : DEN_W'(s1_ff.sat_den);
      if (s1_ff.side.mode == MODE_RGB2HSV || s1_ff.side.mode == MODE_RGB2HSL) begin
         s2_in.lane[0].den = s1_ff.side.hue_zero ? DEN_W'(1) : DEN_W'(s1_ff.delta);
         s2_in.lane[0].num = (NUM_W'(s1_ff.diff) << HUE_FRAC_BITS) +
                             NUM_W'(s1_ff.delta >> 1);
         s2_in.lane[1].den = sden;
         s2_in.lane[1].num = (NUM_W'(s1_ff.delta) << CH_W) - NUM_W'(s1_ff.delta) +
                             NUM_W'(sden >> 1);
         s2_in.lane[2].den = DEN_W'(1);
      end else begin
         for (int i = 0; i < 3; i++) s2_in.lane[i].den = rden;
         s2_in.lane[0].num = base_sh + NUM_W'(rden >> 1);
         s2_in.lane[1].num = base_sh + NUM_W'(NUM_W'(s1_ff.span) * NUM_W'(s1_ff.w)) +
                             NUM_W'(rden >> 1);
         s2_in.lane[2].num = base_sh + (NUM_W'(s1_ff.span) << HUE_FRAC_BITS) +
                             NUM_W'(rden >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_ready && in_valid) s1_ff <= s1_in;
      if (s2_ready && s1_valid_ff) s2_ff <= s2_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rgbhsv_div_cell.sv =====
// One restoring-division cell: resolves quotient bit SHIFT on all three lanes
// and hands the request to the next cell. Depends on rgbhsv_pkg.
`default_nettype none
module rgbhsv_div_cell
   import rgbhsv_pkg::*;
#(
   parameter int SHIFT = 0
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire work_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output work_type      out_data
);

   localparam int EXT_W = DEN_W + QUO_W;

   logic     valid_ff, valid_in;
   work_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      logic [EXT_W-1:0] dsh, rem;
      data_in = in_data;
      for (int i = 0; i < 3; i++) begin
         dsh = EXT_W'(in_data.lane[i].den) << SHIFT;
         rem = EXT_W'(in_data.lane[i].num);
         if (rem >= dsh) begin
            data_in.lane[i].num = NUM_W'(rem - dsh);
            data_in.lane[i].quo = in_data.lane[i].quo | (QUO_W'(1) << SHIFT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/rgb_hsv_hsl_color_converter.sv =====
// Top level of the RGB/HSV/HSL color converter: mode register, front end,
// divider cell chain, result assembly and output register.
// Depends on rgbhsv_pkg, rgbhsv_prep and rgbhsv_div_cell.
//
//   channel   ports                             direction  handshake
//   request   req_valid req_ready req_data      in         valid/ready
//   response  rsp_valid rsp_ready rsp_data      out        valid/ready
//   config    csr_we csr_wdata                  in         write enable
//
// One request per cycle sustained while responses are taken; a request
// passes two front end stages, one divider cell per quotient bit and the
// output register. Each stage stalls only while its successor is full and
// held, so requests keep flowing while a finished response waits.
// Synchronous reset empties the pipeline and sets the mode to RGB to HSV.
`default_nettype none
module rgb_hsv_hsl_color_converter
   import rgbhsv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic [1:0] csr_wdata
);

   mode_type mode_ff;

   // chain[0] is the front end output, chain[QUO_W] the last cell output
   logic     chain_valid [QUO_W+1];
   logic     chain_ready [QUO_W+1];
   work_type chain_data  [QUO_W+1];

   logic    rsp_valid_ff, rsp_valid_in, out_ready;
   rsp_type rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RGB2HSV;
      end else if (csr_we) begin
         mode_ff <= mode_type'(csr_wdata);
      end
   end

   rgbhsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   // most significant quotient bit first
   for (genvar gi = 0; gi < QUO_W; gi++) begin : g_cell
      rgbhsv_div_cell #(.SHIFT(QUO_W - 1 - gi)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[gi]),
         .in_ready  (chain_ready[gi]),
         .in_data   (chain_data[gi]),
         .out_valid (chain_valid[gi+1]),
         .out_ready (chain_ready[gi+1]),
         .out_data  (chain_data[gi+1])
      );
   end

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign chain_ready[QUO_W] = out_ready;
   assign rsp_valid_in = out_ready ? chain_valid[QUO_W] : rsp_valid_ff;

   // assemble the response from the three quotients
   always_comb begin
      work_type         wk;
      logic [HUE_W:0]   off, h;
      logic [CH_W-1:0]  lo, mid, hi, r, g, b, s;
      wk = chain_data[QUO_W];
      rsp_in = '0;
      unique case (wk.side.hue_base)
         HUE_BASE_GREEN: off = HUE_ONE << 1;
         HUE_BASE_BLUE:  off = HUE_ONE << 2;
         default:        off = '0;
      endcase
      // negative offset in the red sector wraps through a full turn
      if (wk.side.neg) begin
         h = ((off == '0) ? HUE_TURN : off) - (HUE_W + 1)'(wk.lane[0].quo);
      end else begin
         h = off + (HUE_W + 1)'(wk.lane[0].quo);
      end
      if (h >= HUE_TURN) h = h - HUE_TURN;
      if (wk.side.hue_zero) h = '0;
      s = (wk.lane[1].quo > QUO_W'(CH_MAX)) ? CH_MAX : CH_W'(wk.lane[1].quo);
      if (wk.side.sat_zero) s = '0;
      lo  = (wk.lane[0].quo > QUO_W'(CH_MAX)) ? CH_MAX : CH_W'(wk.lane[0].quo);
      mid = (wk.lane[1].quo > QUO_W'(CH_MAX)) ? CH_MAX : CH_W'(wk.lane[1].quo);
      hi  = (wk.lane[2].quo > QUO_W'(CH_MAX)) ? CH_MAX : CH_W'(wk.lane[2].quo);
      unique case (wk.side.sector)
         3'd0:    begin r = hi;  g = mid; b = lo;  end
         3'd1:    begin r = mid; g = hi;  b = lo;  end
         3'd2:    begin r = lo;  g = hi;  b = mid; end
         3'd3:    begin r = lo;  g = mid; b = hi;  end
         3'd4:    begin r = mid; g = lo;  b = hi;  end
         default: begin r = hi;  g = lo;  b = mid; end
      endcase
      if (wk.side.mode == MODE_RGB2HSV || wk.side.mode == MODE_RGB2HSL) begin
         rsp_in.out_first  = FIRST_W'(h);
         rsp_in.out_second = s;
         rsp_in.out_third  = wk.side.third;
      end else begin
         rsp_in.out_first  = FIRST_W'(r);
         rsp_in.out_second = g;
         rsp_in.out_third  = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_ready && chain_valid[QUO_W]) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an empty output register lets the whole chain take a request
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request refused with empty output register");

   // forward results always land inside one hue turn
   a_hue_in_turn: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (mode_ff == MODE_RGB2HSV || mode_ff == MODE_RGB2HSL))
      |-> (FIRST_W'(HUE_TURN) > rsp_ff.out_first))
      else $error("hue beyond one turn");

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("response valid right after reset");

endmodule
`default_nettype wire
